@@ rtl/bia_pkg.sv @@
// Shared types, constants and helpers for the bitmap index allocator.
// No dependencies; the RTL files refer to it by scoped names, the testbench files import it.
package bia_pkg;

  // Bitmap geometry
  localparam int MAX_WORDS  = 16;
  localparam int WORD_BITS  = 64;
  localparam int WORD_IDX_W = $clog2(MAX_WORDS);
  localparam int BIT_IDX_W  = $clog2(WORD_BITS);
  localparam int WPTR_W     = WORD_IDX_W + 1;
  localparam int SLOT_W     = 10;
  localparam int COUNT_W    = 11;
  localparam int WIU_W      = 5;

  // Configuration port
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam logic REG_WORDS_IN_USE = 1'b0;
  localparam logic [WIU_W-1:0] WIU_RESET = WIU_W'(MAX_WORDS);

  // Request codes
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  // Response status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_code_t;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EVAL = 1'b1
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // latch the accepted request
    logic eval;   // examine the current word, finish or step on
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic done;   // request resolves on this evaluation
  } dp_stat_t;

  // Index of the lowest set bit; zero when none is set
  function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_IDX_W-1:0] n;
    n = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) n = BIT_IDX_W'(i);
    end
    return n;
  endfunction

endpackage

@@ rtl/bia_req_if.sv @@
// Request channel: valid/ready handshake carrying an allocate or free.
// Depends on bia_pkg for field widths.
interface bia_req_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [bia_pkg::SLOT_W-1:0]   slot_index;

  modport source (output valid, cmd, slot_index, input ready);
  modport sink   (input valid, cmd, slot_index, output ready);
endinterface

@@ rtl/bia_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one result per request.
// Depends on bia_pkg for field widths.
interface bia_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bia_pkg::SLOT_W-1:0]    alloc_index;
  logic [1:0]                    status;
  logic [bia_pkg::COUNT_W-1:0]   used_count;

  modport source (output valid, alloc_index, status, used_count, input ready);
  modport sink   (input valid, alloc_index, status, used_count, output ready);
endinterface

@@ rtl/bia_ctrl.sv @@
// Allocator controller: request handshake, evaluation sequencing, output valid.
// Depends on bia_pkg.
module bia_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bia_pkg::dp_stat_t stat,
  output bia_pkg::dp_cmd_t  ctl
);

  bia_pkg::ctrl_state_t state, state_next;
  logic out_valid_next;
  logic out_free;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bia_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Output slot is free when empty or being drained this cycle
  assign out_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    ctl            = '0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      bia_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = bia_pkg::S_EVAL;
        end
      end
      bia_pkg::S_EVAL: begin
        // hold off until the result has somewhere to go
        if (out_free) begin
          ctl.eval = 1'b1;
          if (stat.done) begin
            out_valid_next = 1'b1;
            state_next     = bia_pkg::S_IDLE;
          end
        end
      end
      default: state_next = bia_pkg::S_IDLE;
    endcase
  end

endmodule

@@ rtl/bia_dp.sv @@
// Allocator datapath: occupancy bitmap, hint, used count, word scan and result.
// Depends on bia_pkg.
module bia_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  bia_pkg::dp_cmd_t              ctl,
  output bia_pkg::dp_stat_t             stat,
  input  logic                          req_cmd_in,
  input  logic [bia_pkg::SLOT_W-1:0]    req_idx_in,
  input  logic [bia_pkg::WIU_W-1:0]     words_in_use,
  output logic [bia_pkg::SLOT_W-1:0]    alloc_index,
  output logic [1:0]                    status,
  output logic [bia_pkg::COUNT_W-1:0]   used_count
);

  logic [bia_pkg::WORD_BITS-1:0]  occ [bia_pkg::MAX_WORDS];
  logic [bia_pkg::WORD_IDX_W-1:0] hint;
  logic [bia_pkg::COUNT_W-1:0]    used;
  logic                           req_cmd;
  logic [bia_pkg::SLOT_W-1:0]     req_idx;
  logic [bia_pkg::WPTR_W-1:0]     wptr;

  logic [bia_pkg::WIU_W-1:0]      words;
  logic [bia_pkg::COUNT_W-1:0]    capacity;
  logic [bia_pkg::WORD_BITS-1:0]  cur_word;
  logic [bia_pkg::WORD_BITS-1:0]  free_mask;
  logic                           found;
  logic [bia_pkg::BIT_IDX_W-1:0]  alloc_bit;
  logic [bia_pkg::BIT_IDX_W-1:0]  free_bit;
  logic                           pool_full;
  logic                           out_of_range;
  logic                           bit_held;
  logic                           do_set;
  logic                           do_clear;
  logic [bia_pkg::WORD_IDX_W-1:0] word_sel;
  logic [bia_pkg::COUNT_W-1:0]    used_next;
  logic [bia_pkg::SLOT_W-1:0]     grant;
  bia_pkg::status_code_t          res_status;

  // Active word count saturates at the bitmap size
  assign words    = (words_in_use > bia_pkg::WIU_W'(bia_pkg::MAX_WORDS)) ?
                    bia_pkg::WIU_W'(bia_pkg::MAX_WORDS) : words_in_use;
  assign capacity = bia_pkg::COUNT_W'({words, {bia_pkg::BIT_IDX_W{1'b0}}});

  // Current word and its lowest free bit
  assign word_sel  = wptr[bia_pkg::WORD_IDX_W-1:0];
  assign cur_word  = occ[word_sel];
  assign free_mask = ~cur_word;
  assign found     = |free_mask;
  assign alloc_bit = bia_pkg::lowest_set(free_mask);
  assign free_bit  = req_idx[bia_pkg::BIT_IDX_W-1:0];
  assign bit_held  = cur_word[free_bit];

  // Outcome of this evaluation
  assign pool_full    = (used >= capacity) || (bia_pkg::WIU_W'(wptr) >= words);
  assign out_of_range = bia_pkg::COUNT_W'(req_idx) >= capacity;
  assign do_set       = (req_cmd == bia_pkg::CMD_ALLOC) && !pool_full && found;
  assign do_clear     = (req_cmd == bia_pkg::CMD_FREE) && !out_of_range && bit_held;
  assign stat.done    = (req_cmd == bia_pkg::CMD_FREE) || pool_full || found;

  always_comb begin
    res_status = bia_pkg::ST_OK;
    if (req_cmd == bia_pkg::CMD_ALLOC) begin
      if (pool_full) res_status = bia_pkg::ST_FULL;
    end else if (out_of_range) begin
      res_status = bia_pkg::ST_RANGE;
    end else if (!bit_held) begin
      res_status = bia_pkg::ST_NOT_ALLOC;
    end
  end

  assign grant = do_set ? {word_sel, alloc_bit} : '0;

  always_comb begin
    used_next = used;
    if (do_set) used_next = used + bia_pkg::COUNT_W'(1);
    else if (do_clear && used != '0) used_next = used - bia_pkg::COUNT_W'(1);
  end

  // Request latch and word pointer
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_cmd <= req_cmd_in;
      req_idx <= req_idx_in;
      if (req_cmd_in == bia_pkg::CMD_FREE)
        wptr <= bia_pkg::WPTR_W'(req_idx_in[bia_pkg::SLOT_W-1:bia_pkg::BIT_IDX_W]);
      else
        wptr <= bia_pkg::WPTR_W'(hint);
    end else if (ctl.eval && !stat.done) begin
      wptr <= wptr + bia_pkg::WPTR_W'(1);
    end
  end

  // Bitmap, hint and count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bia_pkg::MAX_WORDS; i++) occ[i] <= '0;
      hint <= '0;
      used <= '0;
    end else if (ctl.eval && stat.done) begin
      used <= used_next;
      if (do_set) begin
        occ[word_sel] <= cur_word | (bia_pkg::WORD_BITS'(1) << alloc_bit);
        hint          <= word_sel;
      end else if (do_clear) begin
        occ[word_sel] <= cur_word & ~(bia_pkg::WORD_BITS'(1) << free_bit);
        if (word_sel < hint) hint <= word_sel;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctl.eval && stat.done) begin
      alloc_index <= grant;
      status      <= res_status;
      used_count  <= used_next;
    end
  end

endmodule

@@ rtl/bitmap_index_allocator_top.sv @@
// Bitmap index allocator, lowest free slot first, 16 words of 64 slots.
// A request is latched on transfer and evaluated one word at a time: a free, or an
// allocate with a free slot in the hint word, resolves on its first evaluation, and
// each full word adds another; the single evaluator takes one request at a time.
// Reset (rst, synchronous): bitmap, hint and count clear at once; words_in_use = 16.
module bitmap_index_allocator_top (
  input  logic                        clk,
  input  logic                        rst,
  bia_req_if.sink                     req,
  bia_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bia_pkg::PADDR_W-1:0] paddr,
  input  logic [bia_pkg::PDATA_W-1:0] pwdata,
  output logic [bia_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  logic [bia_pkg::WIU_W-1:0] words_in_use;
  bia_pkg::dp_cmd_t          ctl;
  bia_pkg::dp_stat_t         stat;
  logic                      wr_en;

  // Configuration register
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite &&
                  (paddr[bia_pkg::PADDR_W-1] == bia_pkg::REG_WORDS_IN_USE);

  always_ff @(posedge clk) begin
    if (rst) begin
      words_in_use <= bia_pkg::WIU_RESET;
    end else if (wr_en) begin
      words_in_use <= pwdata[bia_pkg::WIU_W-1:0];
    end
  end

  assign prdata = (paddr[bia_pkg::PADDR_W-1] == bia_pkg::REG_WORDS_IN_USE) ?
                  bia_pkg::PDATA_W'(words_in_use) : '0;

  // Controller
  bia_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // Datapath
  bia_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .req_cmd_in   (req.cmd),
    .req_idx_in   (req.slot_index),
    .words_in_use (words_in_use),
    .alloc_index  (rsp.alloc_index),
    .status       (rsp.status),
    .used_count   (rsp.used_count)
  );

`ifndef SYNTH
  // One request in flight: no new transfer right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while previous still in flight");

  // Load and evaluate never coincide
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> !ctl.eval)
    else $error("load and eval issued together");

  // Only a successful allocate carries a nonzero index
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != bia_pkg::ST_OK) |-> rsp.alloc_index == '0)
    else $error("nonzero index on failed request");

  // Count never exceeds the bitmap size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.used_count <= bia_pkg::COUNT_W'(bia_pkg::MAX_WORDS * bia_pkg::WORD_BITS))
    else $error("used count beyond bitmap size");
`endif

endmodule

@@ tb/bia_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the bitmap index allocator: mirrors the words_in_use register,
// predicts every response from the accepted requests and compares them in order.
// Depends on bia_pkg and the bia_req_if / bia_rsp_if channel interfaces.
module bia_checker (
  input  logic                        clk,
  input  logic                        rst,
  bia_req_if                          req,
  bia_rsp_if                          rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [bia_pkg::PADDR_W-1:0] paddr,
  input  logic [bia_pkg::PDATA_W-1:0] pwdata,
  output int                          fails,
  output int                          pending,
  output int                          checked,
  output int                          full_seen,
  output int                          reject_seen
);
  import bia_pkg::*;

  localparam logic [PADDR_W-1:0] WIU_ADDR = PADDR_W'(4 * int'(REG_WORDS_IN_USE));

  typedef struct packed {
    logic [SLOT_W-1:0]  grant;
    status_code_t       status;
    logic [COUNT_W-1:0] used;
  } grant_result_t;

  // Shadow allocator state
  logic [WORD_BITS-1:0]  occ_map [MAX_WORDS];
  logic [WORD_IDX_W-1:0] hint_word;
  logic [COUNT_W-1:0]    slots_held;
  logic [WIU_W-1:0]      words_cfg;

  grant_result_t grants_due [$];
  int n_fail;
  int n_checked;
  int n_full;
  int n_reject;

  // Apply one request to the shadow state and return the response it must give
  function automatic grant_result_t serve_request(cmd_t op, logic [SLOT_W-1:0] idx);
    grant_result_t r;
    int words;
    int cap;
    int w;
    int b;
    bit found;
    r.grant  = '0;
    r.status = ST_OK;
    words = (int'(words_cfg) > MAX_WORDS) ? MAX_WORDS : int'(words_cfg);
    cap   = words * WORD_BITS;
    if (op == CMD_ALLOC) begin
      if (int'(slots_held) >= cap) begin
        r.status = ST_FULL;
      end else begin
        // walk up from the hint word to the first word with a clear bit
        w = int'(hint_word);
        found = 1'b0;
        while (w < words && !found) begin
          if (occ_map[w] != '1) begin
            b = 0;
            while (occ_map[w][b]) b++;
            occ_map[w][b] = 1'b1;
            r.grant    = SLOT_W'(w * WORD_BITS + b);
            hint_word  = WORD_IDX_W'(w);
            slots_held = slots_held + COUNT_W'(1);
            found = 1'b1;
          end else begin
            w++;
          end
        end
        if (!found) r.status = ST_FULL;
      end
    end else begin
      if (int'(idx) >= cap) begin
        r.status = ST_RANGE;
      end else begin
        w = int'(idx[SLOT_W-1:BIT_IDX_W]);
        b = int'(idx[BIT_IDX_W-1:0]);
        if (!occ_map[w][b]) begin
          r.status = ST_NOT_ALLOC;
        end else begin
          occ_map[w][b] = 1'b0;
          if (w < int'(hint_word)) hint_word = WORD_IDX_W'(w);
          if (slots_held != '0) slots_held = slots_held - COUNT_W'(1);
        end
      end
    end
    r.used = slots_held;
    return r;
  endfunction

  // Watch register writes, request and response transfers
  always @(posedge clk) begin
    grant_result_t want;
    if (rst) begin
      for (int i = 0; i < MAX_WORDS; i++) occ_map[i] = '0;
      hint_word  = '0;
      slots_held = '0;
      words_cfg  = WIU_RESET;
      grants_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == WIU_ADDR)
        words_cfg = pwdata[WIU_W-1:0];
      if (req.valid && req.ready)
        grants_due.push_back(serve_request(cmd_t'(req.cmd), req.slot_index));
      if (rsp.valid && rsp.ready) begin
        n_checked++;
        if (grants_due.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("mismatch %0d: response with nothing outstanding idx=%0d st=%0d cnt=%0d",
                     n_fail, rsp.alloc_index, rsp.status, rsp.used_count);
        end else begin
          want = grants_due.pop_front();
          if (want.status == ST_FULL) n_full++;
          if (want.status == ST_RANGE || want.status == ST_NOT_ALLOC) n_reject++;
          if (rsp.alloc_index !== want.grant || rsp.status !== want.status ||
              rsp.used_count !== want.used) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("mismatch %0d at response %0d: exp idx=%0d st=%s cnt=%0d",
                       n_fail, n_checked, want.grant, want.status.name(), want.used);
              $display("  got idx=%0d st=%0d cnt=%0d",
                       rsp.alloc_index, rsp.status, rsp.used_count);
            end
          end
        end
      end
    end
    fails       <= n_fail;
    pending     <= grants_due.size();
    checked     <= n_checked;
    full_seen   <= n_full;
    reject_seen <= n_reject;
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, request and response drivers,
// register writes over the APB port and the final verdict.
// Depends on bia_pkg, the channel interfaces, bia_checker and the allocator RTL.
module tb_top;
  import bia_pkg::*;

  localparam logic [PADDR_W-1:0] WIU_ADDR = PADDR_W'(4 * int'(REG_WORDS_IN_USE));
  localparam int ITEMS_TARGET = 1800;
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  bia_req_if req_ch ();
  bia_rsp_if rsp_ch ();

  int fail_count;
  int pending;
  int checked;
  int full_seen;
  int reject_seen;

  int  cycles;
  int  items_sent;
  int  held_guess;
  int  cfg_writes;
  int  holds_done;
  bit  idle_on;
  bit  hold_ask;

  bitmap_index_allocator_top dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bia_checker chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fails       (fail_count),
    .pending     (pending),
    .checked     (checked),
    .full_seen   (full_seen),
    .reject_seen (reject_seen)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Response side: random stall bursts, plus one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask) begin
        hold_ask  = 1'b0;
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 4);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // One request transfer, with an optional idle burst ahead of it
  task automatic send_req(input cmd_t op, input logic [SLOT_W-1:0] idx);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= op;
    req_ch.slot_index <= idx;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  // Wait until every response owed has come back
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // APB write of words_in_use; upper data bits carry noise
  task automatic cfg_write(input logic [WIU_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WIU_ADDR;
    pwdata  <= ($urandom() & ~PDATA_W'(32'h1f)) | PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_writes++;
  endtask

  // Random traffic under one register setting; the request valid is already low
  task automatic run_phase(input logic [WIU_W-1:0] wiu, input int n_items,
                           input int alloc_pct, input bit squeeze);
    int cap;
    int hi;
    int pick;
    logic [SLOT_W-1:0] idx;
    wait_drained();
    cfg_write(wiu);
    cap = ((int'(wiu) > MAX_WORDS) ? MAX_WORDS : int'(wiu)) * WORD_BITS;
    if (squeeze) hold_ask = 1'b1;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      idx  = SLOT_W'($urandom());
      if (pick < alloc_pct) begin
        send_req(CMD_ALLOC, idx);
        if (held_guess < 1024) held_guess++;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 8 && cap > 0) begin
          // frees aimed at the low region where grants cluster
          hi = held_guess + 8;
          if (hi > cap) hi = cap;
          idx = SLOT_W'($urandom_range(0, hi - 1));
          if (held_guess > 0) held_guess--;
        end else if (pick < 9 && cap < 1024) begin
          idx = SLOT_W'($urandom_range(cap, 1023));
        end
        send_req(CMD_FREE, idx);
      end
    end
    req_ch.valid <= 1'b0;
  endtask

  // Stimulus and verdict
  initial begin
    logic [WIU_W-1:0] wiu_plan [16];
    int ph;
    int n;
    int pct;
    wiu_plan = '{5'd1, 5'd4, 5'd16, 5'd0, 5'd2, 5'd31, 5'd5, 5'd1,
                 5'd17, 5'd3, 5'd16, 5'd8, 5'd2, 5'd4, 5'd1, 5'd6};
    items_sent = 0;
    held_guess = 0;
    cfg_writes = 0;
    holds_done = 0;
    idle_on    = 1'b1;
    hold_ask   = 1'b0;
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.cmd        <= CMD_ALLOC;
    req_ch.slot_index <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset capacity of 16 words
    send_req(CMD_FREE,  10'd0);      // nothing held yet
    send_req(CMD_ALLOC, 10'd1023);   // index ignored, grants 0
    send_req(CMD_ALLOC, 10'd0);
    send_req(CMD_ALLOC, 10'd682);
    send_req(CMD_FREE,  10'd1);
    send_req(CMD_FREE,  10'd1);      // double free
    send_req(CMD_ALLOC, 10'd341);    // refills the hole at 1
    send_req(CMD_FREE,  10'd1023);   // top slot, never granted
    req_ch.valid <= 1'b0;
    wait_drained();

    // Zero capacity while slots 0..2 stay held
    cfg_write(5'd0);
    send_req(CMD_ALLOC, 10'd0);
    send_req(CMD_FREE,  10'd0);
    send_req(CMD_FREE,  10'd1023);
    req_ch.valid <= 1'b0;
    wait_drained();

    // Single word
    cfg_write(5'd1);
    send_req(CMD_FREE,  10'd64);     // first slot past capacity
    send_req(CMD_FREE,  10'd63);
    send_req(CMD_FREE,  10'd2);
    send_req(CMD_ALLOC, 10'd1023);
    req_ch.valid <= 1'b0;
    wait_drained();

    // Register above the word count saturates
    cfg_write(5'd17);
    send_req(CMD_FREE,  10'd1023);
    send_req(CMD_ALLOC, 10'd0);
    send_req(CMD_FREE,  10'd3);
    req_ch.valid <= 1'b0;
    wait_drained();
    cfg_write(5'd16);
    send_req(CMD_FREE,  10'd0);
    send_req(CMD_FREE,  10'd2);
    req_ch.valid <= 1'b0;

    // Random phases; state carries over from one setting to the next
    ph = 0;
    while (items_sent < ITEMS_TARGET - 150) begin
      n   = (wiu_plan[ph % 16] == 5'd0) ? 30 : $urandom_range(100, 180);
      pct = (ph % 3 == 0) ? 85 : ((ph % 3 == 1) ? 40 : 70);
      idle_on = ($urandom_range(0, 3) != 0);
      if (ph == 0) idle_on = 1'b0;
      run_phase(wiu_plan[ph % 16], n, pct, ph == 0);
      ph++;
    end

    // Closing stretch at full throughput
    idle_on = 1'b0;
    run_phase(5'd16, 150, 60, 1'b0);
    wait_drained();
    repeat (20) @(posedge clk);

    $display("covered %0d requests and %0d responses over %0d register writes",
             items_sent, checked, cfg_writes);
    $display("(word counts 0, 1, 16, 31 among them), pool-full answers %0d,",
             full_seen);
    $display("rejected frees %0d, long receiver hold-offs %0d",
             reject_seen, holds_done);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
